// ----- sv/fld_pkg.sv -----
package fld_pkg;

    // width of the radius register
    localparam int RADIUS_W = 6;

    // largest radius the register can hold
    localparam int RADIUS_LIMIT = (1 << RADIUS_W) - 1;

    // default ceiling on the radius
    localparam int MAX_RADIUS_DEF = 63;

    // one result word
    typedef struct packed {
        logic flag;
        logic last;
    } fld_word_t;

    // control shared by every cell of the reach chain
    typedef struct packed {
        logic shift;
        logic clear;
        logic inject;
    } fld_cell_ctrl_t;

endpackage

// ----- sv/fld_cell.sv -----
module fld_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fld_pkg::fld_cell_ctrl_t ctrl,
    input  logic                    reach_in,
    output logic                    reach_out
);

    // set when a flag lies within this cell's distance of the newest sample
    logic reach_reg;
    logic reach_next;

    // take the neighbor's reach or the new flag on each tick
    always_comb begin
        reach_next = reach_reg;
        if (ctrl.clear) begin
            reach_next = 1'b0;
        end else if (ctrl.shift) begin
            reach_next = reach_in | ctrl.inject;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg <= 1'b0;
        end else begin
            reach_reg <= reach_next;
        end
    end

    assign reach_out = reach_reg;

endmodule

// ----- sv/fld_out_stage.sv -----
module fld_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fld_pkg::fld_word_t push_word,
    output logic               skid_full,
    output logic               m_valid,
    input  logic               m_ready,
    output fld_pkg::fld_word_t m_word
);

    logic               main_valid_reg;
    logic               main_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    fld_pkg::fld_word_t main_word_reg;
    fld_pkg::fld_word_t main_word_next;
    fld_pkg::fld_word_t skid_word_reg;
    fld_pkg::fld_word_t skid_word_next;
    logic               pop;

    assign pop = main_valid_reg && m_ready;

    // output register with one skid word behind it
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_word_next  = main_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_word_next  = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_word_next  = push_word;
                main_valid_next = 1'b1;
            end else begin
                skid_word_next  = push_word;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        main_word_reg <= main_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign skid_full = skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_word    = main_word_reg;

endmodule

// ----- sv/flag_line_dilation.sv -----
// A result is registered in the output stage before it leaves; the first radius words
// of a line make no result until later, as the line's tail is flushed after line_end.
// Throughput: one word per cycle while no flush runs and the skid word is free; a line_end word
// starts the tail flush of the held outputs, one chain position per cycle while the skid is free.
// Reset: radius 0, held count 0, every reach cell cleared; no clearing pass is needed.
// A radius write clears the reach chain and drops any partly received line.
module flag_line_dilation #(
    parameter int MAX_RADIUS = fld_pkg::MAX_RADIUS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [fld_pkg::RADIUS_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_flag_in,
    input  logic                         s_line_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_flag_out,
    output logic                         m_last_out
);

    localparam int EFF_MAX   = (MAX_RADIUS < fld_pkg::RADIUS_LIMIT) ?
                               MAX_RADIUS : fld_pkg::RADIUS_LIMIT;
    localparam int NUM_CELLS = 2 * EFF_MAX;
    localparam int TAP_W     = $clog2(NUM_CELLS);
    localparam int RW        = fld_pkg::RADIUS_W;
    localparam logic [RW-1:0] EFF_MAX_R = RW'(EFF_MAX);

    logic [RW-1:0]           radius_reg;
    logic [RW-1:0]           radius_next;
    logic [RW-1:0]           held_reg;
    logic [RW-1:0]           held_next;
    logic                    flush_reg;
    logic                    flush_next;
    logic [RW-1:0]           eff_r;
    logic [RW:0]             tap_full;
    logic [TAP_W-1:0]        tap_idx;
    logic                    tap_val;
    logic                    accept;
    logic                    flush_step;
    logic                    skid_full;
    logic                    push;
    fld_pkg::fld_word_t      push_word;
    fld_pkg::fld_word_t      m_word;
    fld_pkg::fld_cell_ctrl_t cell_ctrl;
    logic [NUM_CELLS-1:0]    reach;
    logic [NUM_CELLS-1:0]    chain_in;

    // radius clipped to the ceiling
    assign eff_r = (radius_reg > EFF_MAX_R) ? EFF_MAX_R : radius_reg;

    // tap at 2r-1 holds whether any of the last 2r words was flagged
    assign tap_full = {eff_r, 1'b0} - (RW + 1)'(1);
    assign tap_idx  = tap_full[TAP_W-1:0];
    assign tap_val  = (eff_r == '0) ? 1'b0 : reach[tap_idx];

    assign s_ready    = !flush_reg && !skid_full;
    assign accept     = s_valid && s_ready;
    assign flush_step = flush_reg && !skid_full;

    // reach chain: each cell hands its bit to the next on every tick
    assign chain_in = {reach[NUM_CELLS-2:0], 1'b0};

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        fld_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .reach_in  (chain_in[i]),
            .reach_out (reach[i])
        );
    end

    // line control: radius write, fill, steady output, tail flush
    always_comb begin
        radius_next      = radius_reg;
        held_next        = held_reg;
        flush_next       = flush_reg;
        push             = 1'b0;
        push_word        = '0;
        cell_ctrl        = '0;
        cell_ctrl.inject = accept & s_flag_in;
        if (cfg_wr_en) begin
            radius_next     = cfg_wr_data;
            held_next       = '0;
            flush_next      = 1'b0;
            cell_ctrl.clear = 1'b1;
        end else if (accept) begin
            cell_ctrl.shift = 1'b1;
            if (held_reg < eff_r) begin
                held_next = held_reg + RW'(1);
                if (s_line_end) begin
                    flush_next = 1'b1;
                end
            end else begin
                push           = 1'b1;
                push_word.flag = s_flag_in | tap_val;
                push_word.last = s_line_end && (held_reg == '0);
                if (s_line_end && (held_reg == '0)) begin
                    cell_ctrl.clear = 1'b1;
                end else if (s_line_end) begin
                    flush_next = 1'b1;
                end
            end
        end else if (flush_step) begin
            cell_ctrl.shift = 1'b1;
            push            = 1'b1;
            push_word.flag  = tap_val;
            push_word.last  = (held_reg == RW'(1));
            held_next       = held_reg - RW'(1);
            if (held_reg == RW'(1)) begin
                flush_next      = 1'b0;
                cell_ctrl.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            held_reg   <= '0;
            flush_reg  <= 1'b0;
        end else begin
            radius_reg <= radius_next;
            held_reg   <= held_next;
            flush_reg  <= flush_next;
        end
    end

    fld_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .skid_full (skid_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    assign m_flag_out = m_word.flag;
    assign m_last_out = m_word.last;

    // held words never exceed the radius
    assert property (@(posedge aclk) disable iff (!aresetn) held_reg <= eff_r)
        else $error("held count above radius");

    // a flush always has words left to emit
    assert property (@(posedge aclk) disable iff (!aresetn) flush_reg |-> held_reg != '0)
        else $error("flush with nothing held");

    // no word is pushed while the skid word is occupied
    assert property (@(posedge aclk) disable iff (!aresetn) skid_full |-> !push)
        else $error("push into full output stage");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_R          = fld_pkg::MAX_RADIUS_DEF;
    localparam int RADIUS_W       = fld_pkg::RADIUS_W;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 19;
    localparam int NUM_DIRECTED   = 25;

    // one directed step: optional radius write, then one word
    typedef struct packed {
        bit                cfg;
        bit [RADIUS_W-1:0] radius;
        bit                flag;
        bit                last;
        bit                typed;
        bit                want_flag;
        bit                want_last;
    } dir_row_t;

    // pass-through rows after reset and one-word lines at the widest radius are typed in
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{1'b0, 6'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b1, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{1'b0, 6'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b1, 6'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 6'd63, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 6'd3,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [RADIUS_W-1:0] cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_flag_in   = 1'b0;
    logic                s_line_end  = 1'b0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_flag_out;
    logic                m_last_out;

    // dilation predictor state
    logic [RADIUS_W-1:0] pred_radius;
    int                  pred_reach;
    int                  pred_held;

    fld_pkg::fld_word_t dilated_q [$];
    fld_pkg::fld_word_t fresh_q [$];

    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int mismatch_count  = 0;
    int words_checked   = 0;
    int line_words_sent = 0;
    int radius_writes   = 0;
    int stall_count     = 0;

    flag_line_dilation uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_flag_in   (s_flag_in),
        .s_line_end  (s_line_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_flag_out  (m_flag_out),
        .m_last_out  (m_last_out)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int clipped_radius();
        return (int'(pred_radius) > MAX_R) ? MAX_R : int'(pred_radius);
    endfunction

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // forget the line in progress
    task automatic clear_line();
        pred_reach = clipped_radius() + 1;
        pred_held  = 0;
    endtask

    // emit one output position and step the reach counter
    task automatic note_position(input int r, input bit last);
        fld_pkg::fld_word_t w;
        w.flag = 1'b0;
        if (pred_reach <= r) begin
            pred_reach++;
            w.flag = 1'b1;
        end
        w.last = last;
        fresh_q.push_back(w);
    endtask

    // expected outputs caused by one accepted word
    task automatic predict_dilation(input logic flag, input logic last);
        int r;
        r = clipped_radius();
        fresh_q.delete();
        if (flag)
            pred_reach = -r;
        if (pred_held < r) begin
            pred_held++;
            if (pred_reach <= r)
                pred_reach++;
        end else begin
            note_position(r, last && pred_held == 0);
        end
        // tail flush on line end
        if (last) begin
            while (pred_held > 0) begin
                pred_held--;
                note_position(r, pred_held == 0);
            end
            clear_line();
        end
    endtask

    // hold off the sender until every expected word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (dilated_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pred_radius = value;
        clear_line();
        radius_writes++;
    endtask

    // offer one word, wait for it to be taken, then book its results
    task automatic send_word(input logic flag, input logic last,
                             input bit typed, input fld_pkg::fld_word_t want);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_flag_in  <= flag;
        s_line_end <= last;
        do @(posedge aclk); while (!s_ready);
        line_words_sent++;
        predict_dilation(flag, last);
        if (typed)
            dilated_q.push_back(want);
        else
            foreach (fresh_q[i]) dilated_q.push_back(fresh_q[i]);
    endtask

    task automatic send_line(input int len, input bit close);
        int pct;
        case ($urandom_range(0, 4))
            0: pct = 0;
            1: pct = 4;
            2: pct = 15;
            3: pct = 40;
            default: pct = 100;
        endcase
        for (int i = 0; i < len; i++)
            send_word($urandom_range(0, 99) < pct, close && i == len - 1, 1'b0, '0);
    endtask

    // result side: random stalls on m_ready
    initial begin
        int hold;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hold = draw_gap(recv_calm);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each taken result word with the oldest expectation
    always @(posedge aclk) begin
        fld_pkg::fld_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dilated_q.size() == 0) begin
                $error("unexpected word: flag_out %0b last_out %0b", m_flag_out, m_last_out);
                mismatch_count++;
            end else begin
                want = dilated_q.pop_front();
                words_checked++;
                if (m_flag_out !== want.flag) begin
                    $error("flag_out: expected %0b, got %0b", want.flag, m_flag_out);
                    mismatch_count++;
                end
                if (m_last_out !== want.last) begin
                    $error("last_out: expected %0b, got %0b", want.last, m_last_out);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // stimulus
    initial begin
        dir_row_t row;
        fld_pkg::fld_word_t want;
        int plan [7];
        int r;
        int left;
        int len;
        bit first;

        pred_radius = '0;
        clear_line();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed steps
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.cfg)
                write_radius(row.radius);
            want.flag = row.want_flag;
            want.last = row.want_last;
            send_word(row.flag, row.last, row.typed, want);
        end

        // random lines over a spread of radii
        plan = '{1, 0, MAX_R, $urandom_range(3, 62), 2, $urandom_range(3, 62), 5};
        for (int p = 0; p < 7; p++) begin
            r = plan[p];
            write_radius(RADIUS_W'(r));
            send_calm = (p == 3) || ($urandom_range(0, 4) == 0);
            recv_calm = (p == 3) || ($urandom_range(0, 4) == 0);
            left  = PHASE_WORDS;
            first = 1'b1;
            while (left > 0) begin
                // widest radius: a short line, then one long enough to reach steady flow
                if (r == MAX_R)
                    len = first ? $urandom_range(1, 8) : $urandom_range(MAX_R + 1, MAX_R + 7);
                else
                    len = $urandom_range(1, 2 * r + 6);
                if (r != MAX_R && len > left)
                    len = left;
                send_line(len, 1'b1);
                left -= len;
                first = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
            // sometimes leave a partial line for the next radius write to drop
            if (p != 6 && $urandom_range(0, 2) == 0)
                send_line($urandom_range(1, 3), 1'b0);
        end

        send_calm = 1'b0;
        drain_results();

        $display("covered %0d line words across %0d radius writes, radius 0 to %0d",
                 line_words_sent, radius_writes, MAX_R);
        $display("checked %0d dilated words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
